@@ sv/lbp_pkg.sv @@
// Shared types, constants and window functions for the 3x3 local binary pattern block.
// Used by the front end, queue, back end and top level; depends on nothing.
package lbp_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 8;
	localparam int CODE_W     = 8;

	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	localparam logic [CFG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = CFG_WIDTH_W'(640);
	localparam logic [CFG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = CFG_HEIGHT_W'(480);

	// register select is paddr[2]
	localparam logic REG_SEL_WIDTH  = 1'b0;
	localparam logic REG_SEL_HEIGHT = 1'b1;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// window[column][row], column 0 = left, row 0 = top
	typedef logic [2:0][2:0][PIX_W-1:0] lbp_win_t;

	typedef struct packed {
		logic [COL_W-1:0] addr;
		logic [PIX_W-1:0] pix;
		logic             use_older;
		logic             use_newer;
		logic             clear;
		logic             emit_a;
		logic             emit_b;
		logic             frame_end;
		logic             wr_en;
	} lbp_op_t;

	typedef struct packed {
		logic              run_last;
		logic              frame_end;
		logic              row_end;
		logic [CODE_W-1:0] code;
	} lbp_res_t;

	function automatic lbp_win_t lbp_shift(lbp_win_t w, logic [PIX_W-1:0] top,
			logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot);
		lbp_win_t n;
		n[0]    = w[1];
		n[1]    = w[2];
		n[2][0] = top;
		n[2][1] = mid;
		n[2][2] = bot;
		return n;
	endfunction

	function automatic logic [CODE_W-1:0] lbp_code(lbp_win_t w);
		logic [PIX_W-1:0]  ctr;
		logic [CODE_W-1:0] c;
		ctr  = w[1][1];
		c[0] = ctr > w[0][0];
		c[1] = ctr > w[0][1];
		c[2] = ctr > w[0][2];
		c[3] = ctr > w[1][0];
		c[4] = ctr > w[1][2];
		c[5] = ctr > w[2][0];
		c[6] = ctr > w[2][1];
		c[7] = ctr > w[2][2];
		return c;
	endfunction

endpackage

@@ sv/lbp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module lbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/lbp_front.sv @@
// Front end: accepts input items, tracks column/row/drain position and turns
// each item into an operation for the back end. Depends on lbp_pkg.
module lbp_front import lbp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CFG_WIDTH_W-1:0]  image_width,
	input  logic [CFG_HEIGHT_W-1:0] image_height,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [PIX_W-1:0]        s_tdata,   // [7:0] pixel_value
	input  logic                    s_tuser,   // [0] kind
	input  logic                    q_full,
	output logic                    q_push,
	output lbp_op_t                 q_op
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] drain_q;
	logic             draining_q;

	logic [COL_W-1:0] wm1;
	logic [ROW_W-1:0] hm1;
	logic [COL_W-1:0] col_c;
	logic [COL_W-1:0] drain_c;
	logic             last_p;
	logic             last_d;
	logic             row_last;
	logic             is_drain;
	logic             op_ok;
	logic             accept;

	always_comb begin
		if (image_width == '0) begin
			wm1 = '0;
		end else if (image_width > CFG_WIDTH_W'(MAX_WIDTH)) begin
			wm1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = COL_W'(image_width - 1'b1);
		end
		if (image_height == '0) begin
			hm1 = '0;
		end else if (image_height > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
			hm1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = ROW_W'(image_height - 1'b1);
		end
	end

	// clamp positions left beyond a narrowed frame onto its last column
	assign col_c    = (col_q > wm1) ? wm1 : col_q;
	assign drain_c  = (drain_q > wm1) ? wm1 : drain_q;
	assign last_p   = col_q >= wm1;
	assign last_d   = drain_q >= wm1;
	assign row_last = row_q >= hm1;
	assign is_drain = s_tuser == KIND_DRAIN;
	assign op_ok    = is_drain ? draining_q : !draining_q;
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && op_ok;

	always_comb begin
		if (is_drain) begin
			q_op.addr      = drain_c;
			q_op.pix       = '0;
			q_op.use_older = hm1 != '0;
			q_op.use_newer = 1'b1;
			q_op.clear     = drain_c == '0;
			q_op.emit_a    = drain_c != '0;
			q_op.emit_b    = last_d;
			q_op.frame_end = 1'b1;
			q_op.wr_en     = 1'b0;
		end else begin
			q_op.addr      = col_c;
			q_op.pix       = s_tdata;
			q_op.use_older = row_q >= ROW_W'(2);
			q_op.use_newer = row_q != '0;
			q_op.clear     = col_c == '0;
			q_op.emit_a    = (row_q != '0) && (col_c != '0);
			q_op.emit_b    = (row_q != '0) && last_p;
			q_op.frame_end = 1'b0;
			q_op.wr_en     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (q_push) begin
			if (is_drain) begin
				if (last_d) begin
					draining_q <= 1'b0;
					drain_q    <= '0;
				end else begin
					drain_q <= drain_q + 1'b1;
				end
			end else if (last_p) begin
				col_q <= '0;
				if (row_last) begin
					row_q      <= '0;
					draining_q <= 1'b1;
					drain_q    <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

@@ sv/lbp_queue.sv @@
// Two-entry operation queue between front and back end.
// Depends on lbp_pkg for the operation type.
module lbp_queue import lbp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  lbp_op_t push_op,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output lbp_op_t head_op
);

	lbp_op_t    ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_op    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/lbp_back.sv @@
// Back end: line store read, window update, code generation and result buffer.
// Depends on lbp_pkg and lbp_ram.
module lbp_back import lbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  lbp_op_t           q_op,
	output logic              q_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [CODE_W-1:0] m_tdata,   // [7:0] pattern_code
	output logic [1:0]        m_tuser,   // [0] row_end, [1] frame_end
	output logic              m_tlast    // run_last
);

	localparam int LW = 2 * PIX_W;   // {older, newer}

	// stage 1: line store read in flight
	logic             s1_v_q;
	lbp_op_t          op_s1;
	logic             fwd_v_s1;
	logic [LW-1:0]    fwd_s1;
	// stage 2: window update and line store write
	logic             s2_v_q;
	lbp_op_t          op_s2;
	logic [LW-1:0]    rd_s2;

	lbp_win_t         win_q;
	lbp_res_t         res_q [4];
	logic [1:0]       res_wp_q;
	logic [1:0]       res_rp_q;
	logic [2:0]       res_cnt_q;

	logic             exec;
	logic             s2_free;
	logic             s1_adv;
	logic             s1_free;
	logic             w_en;
	logic [COL_W-1:0] w_addr;
	logic [LW-1:0]    w_data;
	logic [LW-1:0]    ram_rdata;
	logic [LW-1:0]    rd_eff_s1;
	logic             hit_s1;
	logic             hit_q;
	logic [PIX_W-1:0] top;
	logic [PIX_W-1:0] mid;
	lbp_win_t         win_base;
	lbp_win_t         win_a;
	lbp_win_t         win_b;
	lbp_res_t         res_a;
	lbp_res_t         res_b;
	lbp_res_t         res_first;
	logic [1:0]       n_push;
	logic             pop_out;

	assign exec    = s2_v_q && (res_cnt_q <= 3'd2);
	assign s2_free = !s2_v_q || exec;
	assign s1_adv  = s1_v_q && s2_free;
	assign s1_free = !s1_v_q || s1_adv;
	assign q_pop   = q_valid && s1_free;

	// move the newer row down to older, store the new pixel as newer
	assign w_en   = exec && op_s2.wr_en;
	assign w_addr = op_s2.addr;
	assign w_data = {rd_s2[PIX_W-1:0], op_s2.pix};

	lbp_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_line_ram (
		.clk   (clk),
		.we    (w_en),
		.waddr (w_addr),
		.wdata (w_data),
		.re    (q_pop),
		.raddr (q_op.addr),
		.rdata (ram_rdata)
	);

	// forward a write that lands after the read of the same column
	assign rd_eff_s1 = fwd_v_s1 ? fwd_s1 : ram_rdata;
	assign hit_s1    = w_en && s1_v_q && (op_s1.addr == w_addr);
	assign hit_q     = w_en && (q_op.addr == w_addr);

	assign top       = op_s2.use_older ? rd_s2[LW-1:PIX_W] : '0;
	assign mid       = op_s2.use_newer ? rd_s2[PIX_W-1:0] : '0;
	assign win_base  = op_s2.clear ? '0 : win_q;
	assign win_a     = lbp_shift(win_base, top, mid, op_s2.pix);
	assign win_b     = lbp_shift(win_a, '0, '0, '0);

	always_comb begin
		res_a.code      = lbp_code(win_a);
		res_a.row_end   = 1'b0;
		res_a.frame_end = 1'b0;
		res_a.run_last  = !op_s2.emit_b;
		res_b.code      = lbp_code(win_b);
		res_b.row_end   = 1'b1;
		res_b.frame_end = op_s2.frame_end;
		res_b.run_last  = 1'b1;
		res_first       = op_s2.emit_a ? res_a : res_b;
		n_push          = exec ? ({1'b0, op_s2.emit_a} + {1'b0, op_s2.emit_b}) : 2'd0;
	end

	assign pop_out  = m_tvalid && m_tready;
	assign m_tvalid = res_cnt_q != 3'd0;
	assign m_tdata  = res_q[res_rp_q].code;
	assign m_tuser  = {res_q[res_rp_q].frame_end, res_q[res_rp_q].row_end};
	assign m_tlast  = res_q[res_rp_q].run_last;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1    <= q_op;
			fwd_v_s1 <= hit_q;
			fwd_s1   <= w_data;
		end else if (hit_s1 && !s1_adv) begin
			fwd_v_s1 <= 1'b1;
			fwd_s1   <= w_data;
		end
		if (s1_adv) begin
			op_s2 <= op_s1;
			rd_s2 <= hit_s1 ? w_data : rd_eff_s1;
		end
		if (n_push != 2'd0) begin
			res_q[res_wp_q] <= res_first;
		end
		if (n_push == 2'd2) begin
			res_q[res_wp_q + 2'd1] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q    <= 1'b0;
			s2_v_q    <= 1'b0;
			win_q     <= '0;
			res_wp_q  <= '0;
			res_rp_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (s1_free) begin
				s1_v_q <= q_pop;
			end
			if (s2_free) begin
				s2_v_q <= s1_adv;
			end
			if (exec) begin
				win_q <= op_s2.emit_b ? win_b : win_a;
			end
			res_wp_q  <= res_wp_q + n_push;
			if (pop_out) begin
				res_rp_q <= res_rp_q + 2'd1;
			end
			res_cnt_q <= res_cnt_q + {1'b0, n_push} - {2'b00, pop_out};
		end
	end

endmodule

@@ sv/local_binary_pattern_3x3.sv @@
// Top level of the 3x3 local binary pattern block: configuration registers and
// the front end, operation queue and back end. Depends on lbp_pkg and all lbp_ modules.
//
//   port group  | role                    | payload
//   ------------+-------------------------+-------------------------------------------
//   s_*         | pixel / drain items in  | tdata[7:0] pixel_value, tuser[0] kind
//   m_*         | LBP codes out           | tdata[7:0] code, tuser row_end/frame_end, tlast run_last
//   p*          | register access (APB)   | 0x0 image_width, 0x4 image_height
//
// One input item is taken every cycle while s_tready is high; results leave at one per cycle
// while m_tready is high. The results of a row equal its pixel count, so a row streams at
// full rate. An item passes the queue, line RAM read and window before its result is valid.
// A stalled output fills a four-entry result buffer, then the back end, the queue and
// finally s_tready drop. Reset clears positions, window and buffers; line RAM is not cleared.
module local_binary_pattern_3x3 import lbp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel_value
	input  logic                  s_tuser,   // [0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [CODE_W-1:0]     m_tdata,   // [7:0] pattern_code
	output logic [1:0]            m_tuser,   // [0] row_end, [1] frame_end
	output logic                  m_tlast    // run_last
);

	logic [CFG_WIDTH_W-1:0]  image_width_q;
	logic [CFG_HEIGHT_W-1:0] image_height_q;
	logic                    cfg_wr;
	logic                    q_full;
	logic                    q_push;
	lbp_op_t                 push_op;
	logic                    q_pop;
	logic                    q_valid;
	lbp_op_t                 head_op;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_SEL_WIDTH:  prdata = APB_DATA_W'(image_width_q);
			REG_SEL_HEIGHT: prdata = APB_DATA_W'(image_height_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_WIDTH_RESET;
			image_height_q <= IMG_HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SEL_WIDTH:  image_width_q  <= pwdata[CFG_WIDTH_W-1:0];
				REG_SEL_HEIGHT: image_height_q <= pwdata[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	lbp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_op         (push_op)
	);

	lbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_op    (head_op)
	);

	lbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_op     (head_op),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
